// ----- sv/linear_probe_hash_table_unit_defines.svh -----
// Assertion macros for the linear probe hash table unit.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LPHT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LPHT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/lpht_pkg.sv -----
// Shared types, codes and sizes of the linear probe hash table unit.
// No dependencies.
`timescale 1ns / 1ps
package lpht_pkg;
   localparam int unsigned SLOT_BITS = 8;
   localparam int unsigned TABLE_SIZE = 1 << SLOT_BITS;
   localparam int unsigned KEY_BYTES = 8;
   localparam int unsigned VALUE_BYTES = 8;
   localparam logic [8:0] MAX_ENTRIES_RESET = 9'd115;

   typedef enum logic [1:0] {
      OP_SET = 2'd0, OP_GET = 2'd1, OP_DELETE = 2'd2, OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0, ST_UPDATED = 3'd1, ST_FOUND = 3'd2, ST_NOT_FOUND = 3'd3,
      ST_DELETED = 3'd4, ST_FULL = 3'd5, ST_CLEARED = 3'd6, ST_UNUSED = 3'd7
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] key;
      logic [3:0]  key_length;
      logic [63:0] value;
      logic [3:0]  value_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] value_out;
      logic [3:0]  value_length_out;
      logic [7:0]  slot_index;
      logic [8:0]  entry_count;
   } rsp_type;

   // hash unit control
   typedef struct packed {
      logic        start;
      logic [63:0] key;
      logic [3:0]  key_length;
   } hash_ctl_type;

   typedef struct packed {
      logic                 done;
      logic [SLOT_BITS-1:0] slot;
   } hash_sts_type;

   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < n) m[i*8 +: 8] = 8'hFF;
      end
      return m;
   endfunction
endpackage

// ----- sv/lpht_stream_if.sv -----
// Valid/ready channel carrying one payload of a given type.
// No dependencies; the payload type is a parameter.
`timescale 1ns / 1ps
interface lpht_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/lpht_hash.sv -----
// One-at-a-time hash, one key byte per cycle, then three finishing steps.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
module lpht_hash (
   input  logic                  clock,
   input  logic                  reset,
   input  lpht_pkg::hash_ctl_type ctl,
   output lpht_pkg::hash_sts_type sts
);
   import lpht_pkg::*;
   logic [31:0] h_ff, h_in;
   logic [63:0] k_ff, k_in;
   logic [3:0]  n_ff, n_in;
   logic [1:0]  fin_ff, fin_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] b, t;

   always_comb begin
      h_in = h_ff; k_in = k_ff; n_in = n_ff; fin_in = fin_ff;
      busy_in = busy_ff; done_in = 1'b0;
      b = {{24{k_ff[7]}}, k_ff[7:0]};
      t = '0;
      if (ctl.start) begin
         h_in = '0; k_in = ctl.key; n_in = ctl.key_length; fin_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff != 4'd0) begin
            t = h_ff + b;
            t = t + (t << 10);
            h_in = t ^ (t >> 6);
            k_in = k_ff >> 8;
            n_in = n_ff - 4'd1;
         end else begin
            unique case (fin_ff)
               2'd0: h_in = h_ff + (h_ff << 3);
               2'd1: h_in = h_ff ^ (h_ff >> 11);
               default: begin
                  h_in = h_ff + (h_ff << 15);
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            endcase
            fin_in = fin_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      h_ff <= h_in; k_ff <= k_in; n_ff <= n_in; fin_ff <= fin_in;
   end

   assign sts.done = done_ff;
   assign sts.slot = h_ff[SLOT_BITS-1:0];
endmodule

// ----- sv/linear_probe_hash_table_unit.sv -----
// Linear probe hash table: 256 slots of up to 8-byte keys and values.
// Depends on lpht_pkg, lpht_stream_if, lpht_hash and the assertion header.
// One request at a time. A set, get or delete first hashes its key in the
// shared byte-serial hash unit, then for each probed slot reads the slot
// memory and compares, plus a step to write and a step to present the
// response. A clear walks all 256 slots, one per cycle, dropping their
// occupied and tombstone flags. After reset nothing needs clearing: the
// flags are flip-flops cleared at once. The response waits in its own
// register, and the next request is taken once it has been accepted.
// max_entries is written through the csr channel.
`timescale 1ns / 1ps
`include "linear_probe_hash_table_unit_defines.svh"
module linear_probe_hash_table_unit (
   input logic clock,
   input logic reset,
   lpht_stream_if.sink   req,
   lpht_stream_if.source rsp,
   lpht_stream_if.sink   csr
);
   import lpht_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_HASH, S_READ, S_CHECK, S_DONE, S_CLEAR, S_RESP
   } state_type;

   localparam logic [SLOT_BITS:0] TABLE_CNT = (SLOT_BITS + 1)'(TABLE_SIZE);

   // slot memory: key, key length, value, value length
   logic [63:0] key_mem [TABLE_SIZE];
   logic [3:0]  klen_mem [TABLE_SIZE];
   logic [63:0] val_mem [TABLE_SIZE];
   logic [3:0]  vlen_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] occ_ff, occ_in, tomb_ff, tomb_in;

   state_type            state_ff, state_in;
   req_type              r_ff, r_in;
   rsp_type              o_ff, o_in;
   logic [8:0]           max_ff, max_in, cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0] s_ff, s_in, tslot_ff, tslot_in;
   logic [SLOT_BITS:0]   n_ff, n_in;
   logic                 have_t_ff, have_t_in;
   logic                 occ_rd_ff, tomb_rd_ff;
   logic [63:0]          key_rd_ff, val_rd_ff;
   logic [3:0]           klen_rd_ff, vlen_rd_ff;
   logic                 found_ff, found_in, fok_ff, fok_in;
   logic [SLOT_BITS-1:0] hit_ff, hit_in, free_ff, free_in;
   logic                 wr_en;
   logic [SLOT_BITS-1:0] wr_slot;
   logic                 wr_key;
   hash_ctl_type         hctl;
   hash_sts_type         hsts;
   logic [3:0]           klen_n, vlen_n;

   lpht_hash u_hash (.clock(clock), .reset(reset), .ctl(hctl), .sts(hsts));

   // clamp the lengths as the request comes in
   always_comb begin
      klen_n = req.payload.key_length;
      if (klen_n == 4'd0) klen_n = 4'd1;
      if (klen_n > 4'(KEY_BYTES)) klen_n = 4'(KEY_BYTES);
      vlen_n = req.payload.value_length;
      if (vlen_n > 4'(VALUE_BYTES)) vlen_n = 4'(VALUE_BYTES);
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.payload = o_ff;

   always_comb begin
      state_in = state_ff; r_in = r_ff; o_in = o_ff; max_in = max_ff; cnt_in = cnt_ff;
      s_in = s_ff; tslot_in = tslot_ff; n_in = n_ff; have_t_in = have_t_ff;
      occ_in = occ_ff; tomb_in = tomb_ff;
      found_in = found_ff; fok_in = fok_ff; hit_in = hit_ff; free_in = free_ff;
      wr_en = 1'b0; wr_key = 1'b0; wr_slot = hit_ff;
      hctl.start = 1'b0; hctl.key = r_ff.key; hctl.key_length = r_ff.key_length;
      unique case (state_ff)
         S_IDLE: begin
            if (csr.valid) max_in = csr.payload;
            if (req.valid) begin
               r_in.operation = req.payload.operation;
               r_in.key_length = klen_n;
               r_in.value_length = vlen_n;
               r_in.key = req.payload.key & byte_mask(klen_n);
               r_in.value = req.payload.value & byte_mask(vlen_n);
               hctl.key = r_in.key; hctl.key_length = klen_n;
               if (op_type'(req.payload.operation) == OP_CLEAR) begin
                  s_in = '0; state_in = S_CLEAR;
               end else begin
                  hctl.start = 1'b1; state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hsts.done) begin
               s_in = hsts.slot; n_in = '0; have_t_in = 1'b0;
               found_in = 1'b0; fok_in = 1'b0; state_in = S_READ;
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            priority if (occ_rd_ff && klen_rd_ff == r_ff.key_length
                         && key_rd_ff == r_ff.key) begin
               found_in = 1'b1; hit_in = s_ff; state_in = S_DONE;
            end else if (!occ_rd_ff && !tomb_rd_ff) begin
               fok_in = 1'b1; free_in = have_t_ff ? tslot_ff : s_ff; state_in = S_DONE;
            end else begin
               if (!occ_rd_ff && !have_t_ff) begin
                  have_t_in = 1'b1; tslot_in = s_ff;
               end
               s_in = s_ff + 1'b1;
               n_in = n_ff + 1'b1;
               if (n_ff + 1'b1 == TABLE_CNT) begin
                  fok_in = have_t_ff || !occ_rd_ff;
                  free_in = have_t_ff ? tslot_ff : s_ff;
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            o_in = '0;
            o_in.status = ST_NOT_FOUND;
            unique case (op_type'(r_ff.operation))
               OP_SET: begin
                  if (found_ff) begin
                     wr_en = 1'b1; wr_slot = hit_ff;
                     o_in.status = ST_UPDATED; o_in.slot_index = hit_ff;
                  end else if (cnt_ff >= max_ff || !fok_ff) begin
                     o_in.status = ST_FULL;
                  end else begin
                     wr_en = 1'b1; wr_key = 1'b1; wr_slot = free_ff;
                     occ_in[free_ff] = 1'b1; tomb_in[free_ff] = 1'b0;
                     cnt_in = cnt_ff + 9'd1;
                     o_in.status = ST_INSERTED; o_in.slot_index = free_ff;
                  end
               end
               OP_GET: begin
                  if (found_ff) begin
                     o_in.status = ST_FOUND; o_in.slot_index = hit_ff;
                     o_in.value_out = val_rd_ff; o_in.value_length_out = vlen_rd_ff;
                  end
               end
               default: begin
                  if (found_ff) begin
                     occ_in[hit_ff] = 1'b0; tomb_in[hit_ff] = 1'b1;
                     if (cnt_ff != 9'd0) cnt_in = cnt_ff - 9'd1;
                     o_in.status = ST_DELETED; o_in.slot_index = hit_ff;
                  end
               end
            endcase
            o_in.entry_count = cnt_in;
            state_in = S_RESP;
         end
         S_CLEAR: begin
            occ_in[s_ff] = 1'b0; tomb_in[s_ff] = 1'b0;
            s_in = s_ff + 1'b1;
            if (s_ff == SLOT_BITS'(TABLE_SIZE - 1)) begin
               cnt_in = '0;
               o_in = '0; o_in.status = ST_CLEARED;
               state_in = S_RESP;
            end
         end
         default: begin
            if (rsp.ready) state_in = S_IDLE;
         end
      endcase
   end

   // the last read slot stays in the read registers, so a get hit
   // finds its value there when DONE runs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; max_ff <= MAX_ENTRIES_RESET; cnt_ff <= '0;
         occ_ff <= '0; tomb_ff <= '0;
      end else begin
         state_ff <= state_in; max_ff <= max_in; cnt_ff <= cnt_in;
         occ_ff <= occ_in; tomb_ff <= tomb_in;
      end
      r_ff <= r_in; o_ff <= o_in; s_ff <= s_in; tslot_ff <= tslot_in; n_ff <= n_in;
      have_t_ff <= have_t_in; found_ff <= found_in; fok_ff <= fok_in;
      hit_ff <= hit_in; free_ff <= free_in;
      occ_rd_ff <= occ_ff[s_ff]; tomb_rd_ff <= tomb_ff[s_ff];
      if (state_ff == S_READ) begin
         key_rd_ff <= key_mem[s_ff]; klen_rd_ff <= klen_mem[s_ff];
         val_rd_ff <= val_mem[s_ff]; vlen_rd_ff <= vlen_mem[s_ff];
      end
      if (wr_en) begin
         val_mem[wr_slot] <= r_ff.value; vlen_mem[wr_slot] <= r_ff.value_length;
         if (wr_key) begin
            key_mem[wr_slot] <= r_ff.key; klen_mem[wr_slot] <= r_ff.key_length;
         end
      end
   end

   `LPHT_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, cnt_ff <= 9'(TABLE_SIZE))
   `LPHT_ASSERT_IMPL(a_no_overlap, clock, reset, 1'b1, (occ_ff & tomb_ff) == '0)
   `LPHT_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(o_ff))
   `LPHT_ASSERT_NEXT(a_clear_resp, clock, reset, state_ff == S_CLEAR && state_in == S_RESP, occ_ff == '0 && cnt_ff == 9'd0)
endmodule

// ----- verif/tb_linear_probe_hash_table_unit.sv -----
// Testbench for the linear probe hash table unit: directed and random requests
// are checked against a behavioral table model held in this file.
// Depends on lpht_pkg, lpht_stream_if and the linear_probe_hash_table_unit RTL.
`timescale 1ns / 1ps
module tb_linear_probe_hash_table_unit;
   import lpht_pkg::*;

   logic clock;
   logic reset;

   lpht_stream_if #(.payload_type(req_type))    req_ch ();
   lpht_stream_if #(.payload_type(rsp_type))    rsp_ch ();
   lpht_stream_if #(.payload_type(logic [8:0])) csr_ch ();

   linear_probe_hash_table_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // table model state
   logic [63:0] mdl_key [TABLE_SIZE];
   logic [3:0]  mdl_klen [TABLE_SIZE];
   logic [63:0] mdl_val [TABLE_SIZE];
   logic [3:0]  mdl_vlen [TABLE_SIZE];
   bit          mdl_occ [TABLE_SIZE];
   bit          mdl_tomb [TABLE_SIZE];
   int unsigned mdl_count;
   int unsigned mdl_limit;

   rsp_type     expected_rsps[$];
   int          mismatch_count;
   int          idle_cycles;
   bit          timed_out;
   bit          rsp_stall_on;

   localparam int WATCHDOG_LIMIT = 20000;

   // one-at-a-time hash over signed key bytes, masked to the table
   function automatic logic [7:0] slot_hash(logic [63:0] k, int unsigned len);
      logic [31:0] h;
      logic [31:0] b;
      h = '0;
      for (int i = 0; i < len; i++) begin
         b = {{24{k[i*8+7]}}, k[i*8 +: 8]};
         h = h + b;
         h = h + (h << 10);
         h = h ^ (h >> 6);
      end
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h[7:0];
   endfunction

   function automatic logic [63:0] len_mask(int unsigned n);
      return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
   endfunction

   // apply one request to the model and return the expected response
   function automatic rsp_type table_apply(req_type r);
      rsp_type     o;
      int unsigned klen;
      int unsigned vlen;
      logic [63:0] k;
      logic [63:0] v;
      logic [7:0]  s;
      bit          found;
      bit          free_ok;
      bit          have_tomb;
      logic [7:0]  hit;
      logic [7:0]  free_slot;
      logic [7:0]  tomb;
      o = '0;
      o.status = ST_NOT_FOUND;
      klen = (r.key_length == 0) ? 1 : (r.key_length > 8) ? 8 : r.key_length;
      vlen = (r.value_length > 8) ? 8 : r.value_length;
      k = r.key & len_mask(klen);
      v = r.value & len_mask(vlen);
      if (r.operation == OP_CLEAR) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            mdl_occ[i] = 0;
            mdl_tomb[i] = 0;
         end
         mdl_count = 0;
         o.status = ST_CLEARED;
      end else begin
         found = 0;
         free_ok = 0;
         have_tomb = 0;
         tomb = '0;
         free_slot = '0;
         hit = '0;
         s = slot_hash(k, klen);
         for (int n = 0; n < TABLE_SIZE; n++) begin
            if (mdl_occ[s]) begin
               if (mdl_klen[s] == klen && mdl_key[s] == k) begin
                  found = 1;
                  hit = s;
                  break;
               end
            end else if (mdl_tomb[s]) begin
               if (!have_tomb) begin
                  have_tomb = 1;
                  tomb = s;
               end
            end else begin
               free_ok = 1;
               free_slot = have_tomb ? tomb : s;
               break;
            end
            s = s + 8'd1;
         end
         if (!found && !free_ok && have_tomb) begin
            free_ok = 1;
            free_slot = tomb;
         end
         case (r.operation)
            OP_SET: begin
               if (found) begin
                  mdl_val[hit] = v;
                  mdl_vlen[hit] = 4'(vlen);
                  o.status = ST_UPDATED;
                  o.slot_index = hit;
               end else if (mdl_count >= mdl_limit || !free_ok) begin
                  o.status = ST_FULL;
               end else begin
                  mdl_key[free_slot] = k;
                  mdl_klen[free_slot] = 4'(klen);
                  mdl_val[free_slot] = v;
                  mdl_vlen[free_slot] = 4'(vlen);
                  mdl_occ[free_slot] = 1;
                  mdl_tomb[free_slot] = 0;
                  mdl_count++;
                  o.status = ST_INSERTED;
                  o.slot_index = free_slot;
               end
            end
            OP_GET: begin
               if (found) begin
                  o.status = ST_FOUND;
                  o.slot_index = hit;
                  o.value_out = mdl_val[hit];
                  o.value_length_out = mdl_vlen[hit];
               end
            end
            default: begin
               if (found) begin
                  mdl_occ[hit] = 0;
                  mdl_tomb[hit] = 1;
                  if (mdl_count > 0) mdl_count--;
                  o.status = ST_DELETED;
                  o.slot_index = hit;
               end
            end
         endcase
      end
      o.entry_count = 9'(mdl_count);
      return o;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // drive one request and predict its response at the accepting edge;
   // valid stays high after the accept and is dropped only by a gap or a drain
   task automatic send_request(req_type r, bit allow_gap = 1);
      int g;
      g = allow_gap ? gap_length() : 0;
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      expected_rsps.push_back(table_apply(r));
   endtask

   function automatic req_type make_req(op_type op, logic [63:0] k, logic [3:0] kl,
                                        logic [63:0] v = '0, logic [3:0] vl = 4'd0);
      req_type r;
      r.operation = op;
      r.key = k;
      r.key_length = kl;
      r.value = v;
      r.value_length = vl;
      return r;
   endfunction

   // drop valid, hold until every response is back, then let a clear finish
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_limit(logic [8:0] limit);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.payload <= limit;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      mdl_limit = limit;
   endtask

   // random key drawn from a small pool so gets/deletes hit often
   function automatic req_type random_req(int unsigned pool);
      req_type r;
      int p;
      p = $urandom_range(0, 99);
      r.operation = (p < 45) ? OP_SET : (p < 75) ? OP_GET : (p < 99) ? OP_DELETE : OP_CLEAR;
      if ($urandom_range(0, 9) < 8) begin
         r.key = 64'($urandom_range(0, pool - 1)) | ({$urandom, $urandom} & 64'hFF00_0000_0000_0000);
         r.key_length = 4'($urandom_range(1, 8));
         if ($urandom_range(0, 3) == 0) r.key_length = 4'd8;
      end else begin
         r.key = {$urandom, $urandom};
         r.key_length = 4'($urandom_range(0, 15));
      end
      r.value = {$urandom, $urandom};
      r.value_length = 4'($urandom_range(0, 15));
      return r;
   endfunction

   task automatic test_directed_ops();
      send_request(make_req(OP_GET, 64'h0, 4'd1));
      send_request(make_req(OP_DELETE, 64'h0, 4'd1));
      send_request(make_req(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, '1, 4'd8));
      send_request(make_req(OP_SET, 64'h0, 4'd0, 64'h1234, 4'd15));
      send_request(make_req(OP_SET, 64'h80, 4'd15, 64'hFFFF, 4'd1));
      send_request(make_req(OP_SET, 64'h80, 4'd8, 64'h55, 4'd0));
      send_request(make_req(OP_GET, 64'hAB80, 4'd1));
      send_request(make_req(OP_GET, 64'h80, 4'd8));
      send_request(make_req(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0, 4'd3));
      send_request(make_req(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
      send_request(make_req(OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
      send_request(make_req(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
      send_request(make_req(OP_SET, 64'h7F, 4'd1, 64'h9, 4'd1));
      send_request(make_req(OP_DELETE, 64'h0, 4'd0));
      send_request(make_req(OP_CLEAR, 64'h0, 4'd1));
      send_request(make_req(OP_GET, 64'h80, 4'd8));
   endtask

   // fill to max_entries with the limit at zero and then at three
   task automatic test_full_by_count();
      write_limit(9'd0);
      send_request(make_req(OP_SET, 64'h1, 4'd1, 64'h1, 4'd1));
      write_limit(9'd3);
      for (int i = 0; i < 5; i++)
         send_request(make_req(OP_SET, 64'(i + 10), 4'd2, 64'(i), 4'd4));
      send_request(make_req(OP_SET, 64'd10, 4'd2, 64'hBEEF, 4'd2));
      send_request(make_req(OP_CLEAR, 64'h0, 4'd1));
   endtask

   // full table: every slot taken, then probes that walk the whole table
   task automatic test_full_table();
      write_limit(9'd256);
      for (int i = 0; i < 257; i++)
         send_request(make_req(OP_SET, 64'(i), 4'd2, 64'(i * 3), 4'd8), 0);
      send_request(make_req(OP_GET, 64'h1234_5678, 4'd8));
      send_request(make_req(OP_DELETE, 64'd77, 4'd2));
      send_request(make_req(OP_DELETE, 64'd140, 4'd2));
      send_request(make_req(OP_GET, 64'hDEAD, 4'd8));
      send_request(make_req(OP_SET, 64'hDEAD, 4'd8, 64'h1, 4'd1));
      send_request(make_req(OP_SET, 64'hBEEF, 4'd8, 64'h2, 4'd1));
      send_request(make_req(OP_SET, 64'hCAFE, 4'd8, 64'h3, 4'd1));
      send_request(make_req(OP_CLEAR, 64'h0, 4'd1));
   endtask

   task automatic test_random_mix();
      int unsigned limits[4] = '{9'd115, 9'd256, 9'd20, 9'd511};
      for (int ph = 0; ph < 4; ph++) begin
         write_limit(9'(limits[ph]));
         for (int i = 0; i < 400; i++)
            send_request(random_req((ph == 2) ? 32 : 200));
      end
   endtask

   // response side: random stall, compare against oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            a = rsp_ch.payload;
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected response %p", a);
            end else begin
               e = expected_rsps.pop_front();
               if (a !== e) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) $display("mismatch: expected %p actual %p", e, a);
               end
            end
         end
         if ($urandom_range(0, 199) == 0) rsp_stall_on <= ~rsp_stall_on;
         rsp_ch.ready <= rsp_stall_on ? 1'b1 : ($urandom_range(0, 99) < 60);
      end
   end

   // watchdog: cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      rsp_stall_on = 1'b0;
      mismatch_count = 0;
      idle_cycles = 0;
      timed_out = 1'b0;
      mdl_count = 0;
      mdl_limit = MAX_ENTRIES_RESET;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         mdl_occ[i] = 0;
         mdl_tomb[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      test_full_by_count();
      test_full_table();
      test_random_mix();
      wait_drained();
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
